// ===== rtl/arl_pkg.sv =====
package arl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 64;
  localparam int TYPE_W      = 8;
  localparam int RIDX_W      = 10;
  localparam int STATUS_W    = 3;

  localparam logic [TYPE_W-1:0] CHAR_UPPER_T = 8'h54;
  localparam logic [TYPE_W-1:0] CHAR_LOWER_T = 8'h74;
  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // load or match index as reported on the result port, masked or zero-extended
  function automatic logic [RIDX_W-1:0] to_region_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+RIDX_W-1:0] wide;
    wide = {{RIDX_W{1'b0}}, idx};
    return wide[RIDX_W-1:0];
  endfunction

endpackage

// ===== rtl/arl_ram.sv =====
module arl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/arl_ctrl.sv =====
module arl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  arl_pkg::dp_status_t status,
  output arl_pkg::dp_cmd_t    cmd
);
  import arl_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = status.start_scan ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (status.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.capture     = 1'b0;
    cmd.rd_en       = 1'b0;
    cmd.result_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      S_SCAN_END: begin
      end
      S_RESULT: begin
        cmd.result_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |=> state_r == S_IDLE)
    else $error("result load did not return to idle");

  a_scan_end_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN_END |=> state_r == S_RESULT)
    else $error("scan end not followed by result");

endmodule

// ===== rtl/arl_dp.sv =====
module arl_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_mode,
  input  logic [arl_pkg::ADDR_W-1:0]    in_address,
  input  logic [arl_pkg::TYPE_W-1:0]    in_entry_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arl_pkg::STATUS_W-1:0]  out_status,
  output logic [arl_pkg::RIDX_W-1:0]    out_region_index,
  output logic [arl_pkg::ADDR_W-1:0]    out_region_start,
  input  arl_pkg::dp_cmd_t              cmd,
  output arl_pkg::dp_status_t           status
);
  import arl_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mode_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TYPE_W-1:0] type_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [ADDR_W-1:0] best_start_r;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;
  logic [ADDR_W-1:0] rstart_r, rstart_nxt;
  logic [ADDR_W-1:0] rdata;
  logic              we;
  logic              better;

  arl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (addr_r),
    .re    (cmd.rd_en),
    .raddr (scan_idx_r),
    .rdata (rdata)
  );

  assign status.start_scan = in_mode && (in_address != ADDR_ALL_ONES) && (count_r != '0);
  assign status.scan_last  = ({1'b0, scan_idx_r} == (count_r - CNT_W'(1)));
  assign status.out_free   = !out_valid_r || out_ready;

  // later entry wins on equal starts
  assign better = (rdata <= addr_r) && (!hit_r || (rdata >= best_start_r));

  always_comb begin
    status_nxt = ST_NOT_FOUND;
    ridx_nxt   = '0;
    rstart_nxt = '0;
    count_nxt  = count_r;
    we         = 1'b0;
    if (!mode_r) begin
      if (!(type_r inside {CHAR_UPPER_T, CHAR_LOWER_T})) begin
        status_nxt = ST_SKIPPED;
      end else if (count_r >= DEPTH_CNT) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_STORED;
        ridx_nxt   = to_region_index(count_r[IDX_W-1:0]);
        we         = cmd.result_load;
        if (cmd.result_load) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end else if (hit_r) begin
      status_nxt = ST_FOUND;
      ridx_nxt   = to_region_index(best_idx_r);
      rstart_nxt = best_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmd.rd_en;
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.capture) begin
        hit_r <= 1'b0;
      end else if (cmp_vld_r && better) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      addr_r <= in_address;
      type_r <= in_entry_type;
    end
    if (cmd.capture) begin
      scan_idx_r <= '0;
    end else if (cmd.rd_en) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (cmp_vld_r && better) begin
      best_idx_r   <= cmp_idx_r;
      best_start_r <= rdata;
    end
    if (cmd.result_load) begin
      status_r <= status_nxt;
      ridx_r   <= ridx_nxt;
      rstart_r <= rstart_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_region_index = ridx_r;
  assign out_region_start = rstart_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("region count above table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.result_load && out_valid_r && !out_ready))
    else $error("result register overwritten before transaction");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> ({1'b0, scan_idx_r} < count_r))
    else $error("scan read beyond stored entries");

  a_found_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.result_load && mode_r && hit_r) |-> (best_start_r <= addr_r))
    else $error("found start above query address");

endmodule

// ===== rtl/address_to_region_lookup_top.sv =====
// channel  dir  ports                                         transaction when
// in       in   in_valid/in_ready, in_mode, in_address,       in_valid && in_ready
//               in_entry_type
// out      out  out_valid/out_ready, out_status,              out_valid && out_ready
//               out_region_index, out_region_start
//
// a load, or a query of an empty table or of all ones, goes from idle straight to the
// result state; a scanning query reads one entry per cycle through the ram's registered
// read port, then passes scan end; input opens in the cycle after the result load.
// synchronous active-low reset empties the table; no clearing pass is needed.
// the next item is taken while a result waits; a stalled output holds the
// controller in its result state until the result register frees up.
module address_to_region_lookup_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [arl_pkg::ADDR_W-1:0]    in_address,
  input  logic [arl_pkg::TYPE_W-1:0]    in_entry_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arl_pkg::STATUS_W-1:0]  out_status,
  output logic [arl_pkg::RIDX_W-1:0]    out_region_index,
  output logic [arl_pkg::ADDR_W-1:0]    out_region_start
);
  import arl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  arl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  arl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_entry_type    (in_entry_type),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_region_index (out_region_index),
    .out_region_start (out_region_start),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
